/* design/tpd_pkg.sv */
package tpd_pkg;

   localparam int ByteWidth     = 8;
   localparam int TargetWidth   = 2;
   localparam int TagCodeWidth  = 3;
   localparam int CsrDataWidth  = 32;
   localparam int CsrAddrWidth  = 3;

   localparam logic [ByteWidth-1:0] HeaderByteReset = 8'h05;

   // Tags that name a known target.
   localparam logic [ByteWidth-1:0] TagFirst = 8'h01;
   localparam logic [ByteWidth-1:0] TagLast  = 8'h04;

   // Register indexes on the CSR port.
   localparam logic [0:0] RegHeaderByte = 1'b0;

   typedef enum logic [3:0] {
      FRAME_HUNT    = 4'b0001,
      FRAME_ARMED   = 4'b0010,
      FRAME_LENGTH  = 4'b0100,
      FRAME_PAYLOAD = 4'b1000
   } frame_phase_type;

   typedef enum logic [2:0] {
      BLOCK_TAG  = 3'b001,
      BLOCK_SIZE = 3'b010,
      BLOCK_DATA = 3'b100
   } block_phase_type;

   typedef struct packed {
      logic                   write_valid;
      logic [TargetWidth-1:0] target;
      logic [ByteWidth-1:0]   byte_offset;
      logic [ByteWidth-1:0]   value;
      logic                   packet_end;
   } result_type;

endpackage

/* design/tpd_csr.sv */
module tpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tpd_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [tpd_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [tpd_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready,
   output logic [tpd_pkg::ByteWidth-1:0]       header_byte
);

   logic [tpd_pkg::ByteWidth-1:0] header_ff;
   logic [tpd_pkg::ByteWidth-1:0] header_in;
   logic                          reg_index;

   // Registers sit on 4-byte boundaries.
   assign reg_index = paddr[2];
   assign pready    = 1'b1;

   always_comb begin
      header_in = header_ff;
      if (psel && penable && pwrite && pready && (reg_index == tpd_pkg::RegHeaderByte)) begin
         header_in = pwdata[tpd_pkg::ByteWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= tpd_pkg::HeaderByteReset;
      end else begin
         header_ff <= header_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == tpd_pkg::RegHeaderByte) begin
         prdata = {{(tpd_pkg::CsrDataWidth-tpd_pkg::ByteWidth){1'b0}}, header_ff};
      end
   end

   assign header_byte = header_ff;

endmodule

/* design/tpd_parser.sv */
module tpd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [tpd_pkg::ByteWidth-1:0] rx_byte,
   input  logic [tpd_pkg::ByteWidth-1:0] header_byte,
   output logic                          emit,
   output tpd_pkg::result_type           result
);

   tpd_pkg::frame_phase_type         frame_ff, frame_in;
   tpd_pkg::block_phase_type         block_ff, block_in;
   logic [tpd_pkg::ByteWidth-1:0]    length_ff, length_in;
   logic [tpd_pkg::ByteWidth-1:0]    position_ff, position_in;
   logic [tpd_pkg::ByteWidth-1:0]    remaining_ff, remaining_in;
   logic [tpd_pkg::TagCodeWidth-1:0] target_ff, target_in;
   logic [tpd_pkg::ByteWidth-1:0]    offset_ff, offset_in;
   logic [tpd_pkg::ByteWidth-1:0]    next_position;
   logic                             last_byte;
   logic                             known_tag;

   assign next_position = position_ff + 8'd1;
   assign last_byte     = (next_position >= length_ff);
   assign known_tag     = (rx_byte >= tpd_pkg::TagFirst) && (rx_byte <= tpd_pkg::TagLast);

   always_comb begin
      frame_in     = frame_ff;
      block_in     = block_ff;
      length_in    = length_ff;
      position_in  = position_ff;
      remaining_in = remaining_ff;
      target_in    = target_ff;
      offset_in    = offset_ff;
      emit         = 1'b0;
      result       = '0;

      unique case (frame_ff)
         tpd_pkg::FRAME_HUNT: begin
            if (rx_byte == header_byte) begin
               frame_in = tpd_pkg::FRAME_ARMED;
            end
         end
         tpd_pkg::FRAME_ARMED: begin
            if (rx_byte == ~header_byte) begin
               frame_in = tpd_pkg::FRAME_LENGTH;
            end
         end
         tpd_pkg::FRAME_LENGTH: begin
            // A zero length byte is skipped.
            if (rx_byte != '0) begin
               length_in    = rx_byte;
               position_in  = '0;
               block_in     = tpd_pkg::BLOCK_TAG;
               remaining_in = '0;
               target_in    = '0;
               offset_in    = '0;
               frame_in     = tpd_pkg::FRAME_PAYLOAD;
            end
         end
         default: begin
            emit               = last_byte;
            result.packet_end  = last_byte;
            position_in        = next_position;
            if (last_byte) begin
               frame_in = tpd_pkg::FRAME_HUNT;
            end
            unique case (block_ff)
               tpd_pkg::BLOCK_SIZE: begin
                  remaining_in = rx_byte;
                  block_in     = (rx_byte != '0) ? tpd_pkg::BLOCK_DATA : tpd_pkg::BLOCK_TAG;
               end
               tpd_pkg::BLOCK_DATA: begin
                  emit               = 1'b1;
                  result.write_valid = (target_ff != '0);
                  if (target_ff != '0) begin
                     result.target = tpd_pkg::TargetWidth'(target_ff - 3'd1);
                  end
                  result.byte_offset = offset_ff;
                  result.value       = rx_byte;
                  offset_in          = offset_ff + 8'd1;
                  remaining_in       = remaining_ff - 8'd1;
                  if (remaining_ff == 8'd1) begin
                     block_in = tpd_pkg::BLOCK_TAG;
                  end
               end
               default: begin
                  // Tag byte; unknown tags keep their data but mark no target.
                  target_in = known_tag ? rx_byte[tpd_pkg::TagCodeWidth-1:0] : '0;
                  offset_in = '0;
                  block_in  = tpd_pkg::BLOCK_SIZE;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= tpd_pkg::FRAME_HUNT;
         block_ff     <= tpd_pkg::BLOCK_TAG;
         length_ff    <= '0;
         position_ff  <= '0;
         remaining_ff <= '0;
         target_ff    <= '0;
         offset_ff    <= '0;
      end else if (step) begin
         frame_ff     <= frame_in;
         block_ff     <= block_in;
         length_ff    <= length_in;
         position_ff  <= position_in;
         remaining_ff <= remaining_in;
         target_ff    <= target_in;
         offset_ff    <= offset_in;
      end
   end

endmodule

/* design/tlv_packet_deframer.sv */
// Channel   Direction  Ports                                   Moves
// req       in         req_valid, req_ready, req_rx_byte       one received byte per request
// rsp       out        rsp_valid, rsp_ready, rsp_write_valid,  one write or packet-end result
//                      rsp_target, rsp_byte_offset,
//                      rsp_value, rsp_packet_end
// csr       in/out     psel, penable, pwrite, paddr, pwdata,   header byte register
//                      prdata, pready
//
// The block takes one request per cycle while req_ready is high. An accepted
// request is parsed from the input register; the output register puts its result on rsp.
// Reset is synchronous and returns the parser to hunting for a header.
// A request that gives no result is parsed even while a result waits on rsp;
// one that gives a result waits in the input register until the output
// register frees, and req_ready drops for that time.
module tlv_packet_deframer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tpd_pkg::ByteWidth-1:0]       req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_write_valid,
   output logic [tpd_pkg::TargetWidth-1:0]     rsp_target,
   output logic [tpd_pkg::ByteWidth-1:0]       rsp_byte_offset,
   output logic [tpd_pkg::ByteWidth-1:0]       rsp_value,
   output logic                                rsp_packet_end,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tpd_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [tpd_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [tpd_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready
);

   logic [tpd_pkg::ByteWidth-1:0] header_byte;

   // Input register.
   logic                          in_valid_ff, in_valid_in;
   logic [tpd_pkg::ByteWidth-1:0] in_byte_ff, in_byte_in;

   // Output register.
   logic                          out_valid_ff, out_valid_in;
   tpd_pkg::result_type           out_ff, out_in;

   logic                          emit;
   logic                          step;
   tpd_pkg::result_type           result;

   tpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .header_byte (header_byte)
   );

   tpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .header_byte (header_byte),
      .emit        (emit),
      .result      (result)
   );

   // The held byte moves on when it needs no output slot, or the slot is free
   // or being emptied this cycle.
   assign step      = in_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step && emit) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_write_valid = out_ff.write_valid;
   assign rsp_target      = out_ff.target;
   assign rsp_byte_offset = out_ff.byte_offset;
   assign rsp_value       = out_ff.value;
   assign rsp_packet_end  = out_ff.packet_end;

endmodule

/* tb/tb_tlv_packet_deframer.sv */
`timescale 1ns / 100ps

module tb_tlv_packet_deframer;

   localparam int ByteWidth    = tpd_pkg::ByteWidth;
   localparam int TargetWidth  = tpd_pkg::TargetWidth;
   localparam int CsrAddrWidth = tpd_pkg::CsrAddrWidth;
   localparam int CsrDataWidth = tpd_pkg::CsrDataWidth;

   localparam int HalfPeriod   = 10;
   localparam int ResetCycles  = 4;
   localparam int QuietLimit   = 3000;
   localparam int RandomItems  = 1000;
   localparam int SteadyTail   = 150;
   localparam int SettleCycles = 4;
   localparam int DrainCycles  = 8;
   localparam int ReportLimit  = 10;

   localparam logic [CsrAddrWidth-1:0] HeaderByteAddr =
      CsrAddrWidth'(4 * tpd_pkg::RegHeaderByte);

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [ByteWidth-1:0]    req_rx_byte;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_write_valid;
   logic [TargetWidth-1:0]  rsp_target;
   logic [ByteWidth-1:0]    rsp_byte_offset;
   logic [ByteWidth-1:0]    rsp_value;
   logic                    rsp_packet_end;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   tlv_packet_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_write_valid (rsp_write_valid),
      .rsp_target      (rsp_target),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_value       (rsp_value),
      .rsp_packet_end  (rsp_packet_end),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #HalfPeriod clock = ~clock;

   // Shadow copy of the parser. It is advanced once for every accepted request, in
   // acceptance order, so it always knows what the block must emit next.
   logic [ByteWidth-1:0]     header_copy;
   tpd_pkg::frame_phase_type model_frame;
   tpd_pkg::block_phase_type model_block;
   logic [ByteWidth-1:0]     packet_len;
   logic [ByteWidth-1:0]     payload_pos;
   logic [ByteWidth-1:0]     block_left;
   logic [2:0]               active_tag;
   logic [ByteWidth-1:0]     active_offset;

   // Writes and packet-end markers that the block still owes us, oldest first.
   tpd_pkg::result_type pending_writes[$];
   tpd_pkg::result_type observed;
   tpd_pkg::result_type wanted;

   logic [ByteWidth-1:0] staged_bytes[$];

   bit idle_on;
   int stall_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int requests_accepted = 0;
   int results_checked = 0;
   int packets_framed = 0;
   int header_settings = 0;

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // Advances the shadow parser by one received byte and queues the result it
   // gives, if any. Only payload bytes can give a result: data bytes always do,
   // and the last payload byte always does, even when it is a tag or a size.
   task automatic parse_rx_byte(input logic [ByteWidth-1:0] rx);
      logic [ByteWidth-1:0] next_pos;
      logic                 last_byte;
      logic                 emit;
      tpd_pkg::result_type  r;
      r = '0;
      case (model_frame)
         tpd_pkg::FRAME_HUNT: begin
            if (rx == header_copy) model_frame = tpd_pkg::FRAME_ARMED;
         end
         tpd_pkg::FRAME_ARMED: begin
            // Stays armed through anything, a repeated header byte included.
            if (rx == ~header_copy) model_frame = tpd_pkg::FRAME_LENGTH;
         end
         tpd_pkg::FRAME_LENGTH: begin
            // A zero length is dropped and the parser keeps waiting for a length.
            if (rx != '0) begin
               packet_len    = rx;
               payload_pos   = '0;
               model_block   = tpd_pkg::BLOCK_TAG;
               block_left    = '0;
               active_tag    = '0;
               active_offset = '0;
               model_frame   = tpd_pkg::FRAME_PAYLOAD;
            end
         end
         default: begin
            next_pos  = payload_pos + 8'd1;
            last_byte = (next_pos >= packet_len);
            emit      = last_byte;
            case (model_block)
               tpd_pkg::BLOCK_SIZE: begin
                  block_left  = rx;
                  model_block = (rx != '0) ? tpd_pkg::BLOCK_DATA : tpd_pkg::BLOCK_TAG;
               end
               tpd_pkg::BLOCK_DATA: begin
                  emit = 1'b1;
                  // Data under an unknown tag still comes out, only unmarked.
                  if (active_tag != '0) begin
                     r.write_valid = 1'b1;
                     r.target      = active_tag[1:0] - 2'd1;
                  end
                  r.byte_offset = active_offset;
                  r.value       = rx;
                  active_offset = active_offset + 8'd1;
                  block_left    = block_left - 8'd1;
                  if (block_left == '0) model_block = tpd_pkg::BLOCK_TAG;
               end
               default: begin
                  active_tag    = (rx >= tpd_pkg::TagFirst && rx <= tpd_pkg::TagLast)
                                  ? rx[2:0] : 3'd0;
                  active_offset = '0;
                  model_block   = tpd_pkg::BLOCK_SIZE;
               end
            endcase
            payload_pos = next_pos;
            if (last_byte) model_frame = tpd_pkg::FRAME_HUNT;
            if (emit) begin
               r.packet_end = last_byte;
               pending_writes.push_back(r);
            end
         end
      endcase
   endtask

   // Monitor. Everything is sampled at the rising edge, while the block's own
   // registers still hold their pre-edge values. A result can never appear at the
   // same edge as the request that caused it, so checking before predicting is safe.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed = {rsp_write_valid, rsp_target, rsp_byte_offset, rsp_value,
                     rsp_packet_end};
         results_checked++;
         if (pending_writes.size() == 0) begin
            note_failure($sformatf("unexpected result wv=%0d tgt=%0d off=%0d val=%0d end=%0d",
                                   observed.write_valid, observed.target,
                                   observed.byte_offset, observed.value,
                                   observed.packet_end));
         end else begin
            wanted = pending_writes.pop_front();
            if (observed !== wanted) begin
               note_failure($sformatf({"expected wv=%0d tgt=%0d off=%0d val=%0d end=%0d, ",
                                       "got wv=%0d tgt=%0d off=%0d val=%0d end=%0d"},
                                      wanted.write_valid, wanted.target,
                                      wanted.byte_offset, wanted.value, wanted.packet_end,
                                      observed.write_valid, observed.target,
                                      observed.byte_offset, observed.value,
                                      observed.packet_end));
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         requests_accepted++;
         parse_rx_byte(req_rx_byte);
      end
   end

   // Watchdog: a run that makes no progress on either channel for a long stretch
   // is hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no request or result moved for %0d cycles", QuietLimit);
         $display("tlv_packet_deframer verification failed");
         $finish;
      end
   end

   // Receiver back-pressure: random stalls of rsp_ready while idling is on.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Sends one request. It is entered and left at a falling edge; valid is left
   // high so that back-to-back requests keep it high without a dip.
   task automatic push_byte(input logic [ByteWidth-1:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_staged();
      foreach (staged_bytes[i]) push_byte(staged_bytes[i]);
      staged_bytes.delete();
   endtask

   // Stops the sender and waits until every owed result has come out, then lets
   // any trailing byte that gives no result work through the pipeline.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Writes the header register, then reads it back. Call only while settled.
   task automatic program_header(input logic [ByteWidth-1:0] hdr);
      logic [CsrDataWidth-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= HeaderByteAddr;
      pwdata  <= CsrDataWidth'(hdr);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      header_copy = hdr;
      header_settings++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[ByteWidth-1:0] !== hdr) begin
         note_failure($sformatf("header register read %h, expected %h",
                                readback[ByteWidth-1:0], hdr));
      end
   endtask

   // Default header after reset. Covers noise while hunting, a repeated header
   // byte and a stray byte while armed, a dropped zero length, a known and an
   // unknown tag, an empty block, and a block that runs past the packet end.
   task automatic test_sync_and_blocks();
      staged_bytes = '{8'h3C, 8'h05, 8'h05, 8'h77, 8'hFA, 8'h00, 8'h0D,
                       8'h01, 8'h02, 8'h00, 8'hFF,
                       8'h07, 8'h01, 8'hA5,
                       8'h04, 8'h00,
                       8'h02, 8'h05, 8'h80, 8'h7F};
      packets_framed++;
      send_staged();
   endtask

   // Packets whose last byte is a tag, then a size, then a data byte. The first
   // byte is a complement seen while hunting, which must be ignored.
   task automatic test_truncated_packets();
      staged_bytes = '{8'hFA, 8'h05, 8'hFA, 8'h01, 8'h03,
                       8'h05, 8'hFA, 8'h02, 8'h00, 8'h04,
                       8'h05, 8'hFA, 8'h03, 8'h03, 8'h02, 8'h55};
      packets_framed += 3;
      send_staged();
   endtask

   // Header register at both extremes and at a mixed pattern, one packet each.
   task automatic test_header_extremes();
      logic [ByteWidth-1:0] settings[3];
      settings = '{8'h00, 8'hFF, 8'hA5};
      foreach (settings[i]) begin
         settle();
         program_header(settings[i]);
         staged_bytes = '{settings[i], ~settings[i], 8'h04, 8'h02, 8'h01,
                          8'($urandom_range(0, 255)), 8'h01};
         packets_framed++;
         send_staged();
      end
   endtask

   // Mostly well-formed packets with random lengths, tags, sizes and data, with
   // noise, repeated headers, junk while armed and zero lengths mixed in. The
   // header is reprogrammed now and then, and the final stretch runs flat out.
   task automatic test_random_traffic();
      int                   framed_items;
      int                   len;
      int                   n;
      int                   size;
      logic [ByteWidth-1:0] b;
      framed_items = 0;
      while (framed_items < RandomItems) begin
         idle_on = (framed_items < RandomItems - SteadyTail) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 14) == 0) begin
            settle();
            case ($urandom_range(0, 3))
               0:       program_header(8'h00);
               1:       program_header(8'hFF);
               default: program_header(8'($urandom_range(0, 255)));
            endcase
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               do b = 8'($urandom_range(0, 255)); while (b == header_copy);
               staged_bytes.push_back(b);
            end
         end
         staged_bytes.push_back(header_copy);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               do b = 8'($urandom_range(0, 255)); while (b == ~header_copy);
               staged_bytes.push_back(b);
            end
         end
         staged_bytes.push_back(~header_copy);
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) staged_bytes.push_back(8'h00);
         end
         // Long packets are kept rare so that most of the run is short frames.
         len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 20);
         staged_bytes.push_back(8'(len));
         n = 0;
         while (n < len) begin
            b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 4));
            staged_bytes.push_back(b);
            n++;
            if (n < len) begin
               size = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 8);
               staged_bytes.push_back(8'(size));
               n++;
               for (int i = 0; i < size && n < len; i++) begin
                  staged_bytes.push_back(8'($urandom_range(0, 255)));
                  n++;
               end
            end
         end
         framed_items += len + 3;
         packets_framed++;
         send_staged();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_ready   = 1'b1;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      idle_on     = 1'b1;

      header_copy   = tpd_pkg::HeaderByteReset;
      model_frame   = tpd_pkg::FRAME_HUNT;
      model_block   = tpd_pkg::BLOCK_TAG;
      packet_len    = '0;
      payload_pos   = '0;
      block_left    = '0;
      active_tag    = '0;
      active_offset = '0;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_sync_and_blocks();
      test_truncated_packets();
      test_header_extremes();
      test_random_traffic();

      // Drain: stop sending, wait for every owed result, then keep watching for
      // anything the block should not have produced.
      idle_on = 1'b0;
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d requests in %0d framed packets under %0d header settings.",
               requests_accepted, packets_framed, header_settings + 1);
      $display("Checked %0d write and packet-end results; %0d mismatches.",
               results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tlv_packet_deframer verification clean");
      end else begin
         $display("tlv_packet_deframer verification failed");
      end
      $finish;
   end

endmodule
